### sv/h2r_pkg.sv
// Shared types and constants for the HSL to RGB converter.
package h2r_pkg;

	localparam int unsigned HUE_MOD = 360;
	localparam int unsigned PCT_MAX = 100;
	localparam int unsigned SEG_DEG = 60;
	localparam int unsigned SEG_RISE_END = 60;
	localparam int unsigned SEG_FLAT_END = 180;
	localparam int unsigned SEG_FALL_END = 240;
	localparam int unsigned HALF_LIGHT = 50;
	localparam int unsigned OFS_RED = 120;
	localparam int unsigned OFS_BLUE = 240;

	// channel = floor((51 * N + 60000) / 120000), N = channel * 600000
	localparam int unsigned SCALE_MUL = 51;
	localparam int unsigned ROUND_BIAS = 60000;
	localparam longint unsigned DIVISOR = 120000;
	localparam int unsigned RECIP_SHIFT = 42;
	localparam longint unsigned RECIP_VAL = ((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;

	localparam int unsigned HUE_IN_W = 10;
	localparam int unsigned HUE_W = 9;
	localparam int unsigned PCT_W = 7;
	localparam int unsigned QP_W = 14;
	localparam int unsigned DIST_W = 6;
	localparam int unsigned NUM_W = 20;
	localparam int unsigned X_W = 25;
	localparam int unsigned RECIP_W = 26;
	localparam int unsigned PROD_W = X_W + RECIP_W;
	localparam int unsigned CHAN_W = 8;

	typedef logic [HUE_IN_W-1:0] hue_in_t;
	typedef logic [HUE_W-1:0] hue_t;
	typedef logic [PCT_W-1:0] pct_t;
	typedef logic [QP_W-1:0] qp_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [CHAN_W-1:0] chan_t;

	localparam num_t NUM_MAX = NUM_W'(SEG_DEG * 10000);

endpackage

### sv/h2r_front.sv
// Front end: hue wrap, percent clamp (stage 1); q, p and channel hues (stage 2).
module h2r_front (
	input  logic               clk,
	input  logic               en_s1,
	input  logic               en_s2,
	input  h2r_pkg::hue_in_t   hue_deg,
	input  h2r_pkg::pct_t      sat_pct,
	input  h2r_pkg::pct_t      light_pct,
	output h2r_pkg::hue_t      hue_s1,
	output h2r_pkg::pct_t      sat_s1,
	output h2r_pkg::pct_t      light_s1,
	output h2r_pkg::qp_t       q_s2,
	output h2r_pkg::qp_t       p_s2,
	output h2r_pkg::hue_t      tr_s2,
	output h2r_pkg::hue_t      tg_s2,
	output h2r_pkg::hue_t      tb_s2
);
	import h2r_pkg::*;

	localparam int unsigned WQ = 16;

	hue_in_t hue_wrap;
	logic [WQ-1:0] ls;
	logic [WQ-1:0] l100;
	logic [WQ-1:0] s100;
	logic [WQ-1:0] q_nx;
	logic [WQ-1:0] p_nx;

	// hue < 1024, so at most two subtractions of 360
	always_comb begin
		if (hue_deg >= HUE_IN_W'(2 * HUE_MOD)) begin
			hue_wrap = hue_deg - HUE_IN_W'(2 * HUE_MOD);
		end else if (hue_deg >= HUE_IN_W'(HUE_MOD)) begin
			hue_wrap = hue_deg - HUE_IN_W'(HUE_MOD);
		end else begin
			hue_wrap = hue_deg;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hue_s1 <= HUE_W'(hue_wrap);
			sat_s1 <= (sat_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : sat_pct;
			light_s1 <= (light_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : light_pct;
		end
	end

	// one shared L*S product; both branches are linear around it
	always_comb begin
		ls = WQ'(light_s1) * WQ'(sat_s1);
		l100 = WQ'(light_s1) * WQ'(PCT_MAX);
		s100 = WQ'(sat_s1) * WQ'(PCT_MAX);
		if (light_s1 < PCT_W'(HALF_LIGHT)) begin
			q_nx = l100 + ls;
			p_nx = l100 - ls;
		end else begin
			q_nx = l100 + s100 - ls;
			p_nx = l100 - s100 + ls;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			q_s2 <= QP_W'(q_nx);
			p_s2 <= QP_W'(p_nx);
			tg_s2 <= hue_s1;
			tr_s2 <= (hue_s1 >= HUE_W'(HUE_MOD - OFS_RED)) ?
				hue_s1 - HUE_W'(HUE_MOD - OFS_RED) : hue_s1 + HUE_W'(OFS_RED);
			tb_s2 <= (hue_s1 >= HUE_W'(HUE_MOD - OFS_BLUE)) ?
				hue_s1 - HUE_W'(HUE_MOD - OFS_BLUE) : hue_s1 + HUE_W'(OFS_BLUE);
		end
	end

endmodule

### sv/h2r_chan.sv
// Stage 3: piecewise-linear channel value N (channel times 600000).
module h2r_chan (
	input  logic           clk,
	input  logic           en_s3,
	input  h2r_pkg::qp_t   q_s2,
	input  h2r_pkg::qp_t   p_s2,
	input  h2r_pkg::hue_t  t_s2,
	output h2r_pkg::num_t  n_s3
);
	import h2r_pkg::*;

	qp_t span;
	logic [DIST_W-1:0] seg_ofs;
	num_t base_p;
	num_t base_q;
	num_t ramp;
	num_t n_nx;

	always_comb begin
		span = q_s2 - p_s2;
		base_p = NUM_W'(p_s2) * NUM_W'(SEG_DEG);
		base_q = NUM_W'(q_s2) * NUM_W'(SEG_DEG);
		// rising edge uses t, falling edge uses 240 - t
		if (t_s2 < HUE_W'(SEG_RISE_END)) begin
			seg_ofs = DIST_W'(t_s2);
		end else begin
			seg_ofs = DIST_W'(HUE_W'(SEG_FALL_END) - t_s2);
		end
		ramp = NUM_W'(span) * NUM_W'(seg_ofs);
		if (t_s2 < HUE_W'(SEG_RISE_END)) begin
			n_nx = base_p + ramp;
		end else if (t_s2 < HUE_W'(SEG_FLAT_END)) begin
			n_nx = base_q;
		end else if (t_s2 < HUE_W'(SEG_FALL_END)) begin
			n_nx = base_p + ramp;
		end else begin
			n_nx = base_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			n_s3 <= n_nx;
		end
	end

endmodule

### sv/h2r_round.sv
// Stages 4-5: scale by 255 and round half up via reciprocal multiply.
module h2r_round (
	input  logic           clk,
	input  logic           en_s4,
	input  logic           en_s5,
	input  h2r_pkg::num_t  n_s3,
	output h2r_pkg::chan_t chan_s5
);
	import h2r_pkg::*;

	logic [X_W-1:0] x_s4;
	logic [PROD_W-1:0] prod;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			x_s4 <= X_W'(n_s3) * X_W'(SCALE_MUL) + X_W'(ROUND_BIAS);
		end
	end

	// ceil(2^42 / 120000) is exact for x * 120000 < 2^42
	assign prod = PROD_W'(x_s4) * PROD_W'(RECIP_VAL);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			chan_s5 <= prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
		end
	end

endmodule

### sv/hsl_to_rgb_converter_unit.sv
// HSL to RGB converter top level: five-stage pipeline with per-stage valid bits.
// Throughput: one word per cycle while out_stall is low; the multiplier stages set the depth.
// A stalled output only holds the stages behind it that are full: bubbles collapse.
// Reset (arst_n low) clears the valid bits only; data registers are not reset.
module hsl_to_rgb_converter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  h2r_pkg::hue_in_t   hue_deg,
	input  h2r_pkg::pct_t      sat_pct,
	input  h2r_pkg::pct_t      light_pct,
	output logic               out_valid,
	input  logic               out_stall,
	output h2r_pkg::chan_t     red,
	output h2r_pkg::chan_t     green,
	output h2r_pkg::chan_t     blue
);
	import h2r_pkg::*;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	// stage load enables: a stage moves when it is empty or its successor moves
	logic en1, en2, en3, en4, en5;

	hue_t hue_s1;
	pct_t sat_s1;
	pct_t light_s1;
	qp_t q_s2;
	qp_t p_s2;
	hue_t tr_s2, tg_s2, tb_s2;
	num_t nr_s3, ng_s3, nb_s3;

	assign en5 = !v_s5 || !out_stall;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_stall = !en1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// stages 1-2: clamp/wrap, then q, p and per-channel hue
	h2r_front u_front (
		.clk       (clk),
		.en_s1     (en1),
		.en_s2     (en2),
		.hue_deg   (hue_deg),
		.sat_pct   (sat_pct),
		.light_pct (light_pct),
		.hue_s1    (hue_s1),
		.sat_s1    (sat_s1),
		.light_s1  (light_s1),
		.q_s2      (q_s2),
		.p_s2      (p_s2),
		.tr_s2     (tr_s2),
		.tg_s2     (tg_s2),
		.tb_s2     (tb_s2)
	);

	// stage 3: one segment evaluator per channel
	h2r_chan u_chan_r (.clk(clk), .en_s3(en3), .q_s2(q_s2), .p_s2(p_s2), .t_s2(tr_s2),
		.n_s3(nr_s3));
	h2r_chan u_chan_g (.clk(clk), .en_s3(en3), .q_s2(q_s2), .p_s2(p_s2), .t_s2(tg_s2),
		.n_s3(ng_s3));
	h2r_chan u_chan_b (.clk(clk), .en_s3(en3), .q_s2(q_s2), .p_s2(p_s2), .t_s2(tb_s2),
		.n_s3(nb_s3));

	// stages 4-5: rounding scale; stage 5 is the output register
	h2r_round u_round_r (.clk(clk), .en_s4(en4), .en_s5(en5), .n_s3(nr_s3), .chan_s5(red));
	h2r_round u_round_g (.clk(clk), .en_s4(en4), .en_s5(en5), .n_s3(ng_s3), .chan_s5(green));
	h2r_round u_round_b (.clk(clk), .en_s4(en4), .en_s5(en5), .n_s3(nb_s3), .chan_s5(blue));

	// input back-pressure only when every stage holds a word
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input stalled with an empty stage");

	// stage 1 holds reduced hue and clamped percents
	a_s1_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (hue_s1 < HUE_W'(HUE_MOD) && sat_s1 <= PCT_W'(PCT_MAX)
			&& light_s1 <= PCT_W'(PCT_MAX)))
		else $error("stage 1 value out of range");

	// q never below p
	a_qp_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (q_s2 >= p_s2))
		else $error("q below p");

	// channel numerators bounded by a full-scale channel
	a_num_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (nr_s3 <= NUM_MAX && ng_s3 <= NUM_MAX && nb_s3 <= NUM_MAX))
		else $error("channel numerator overflow");

endmodule
